>>> hdl/rrmtf_pkg.sv
package rrmtf_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SRV_RD,
    S_SRV_WR,
    S_SCAN,
    S_SHIFT,
    S_FRONT,
    S_INSERT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  localparam logic [1:0] FUNC_SERVE       = 2'd0;
  localparam logic [1:0] FUNC_EXPEDITE    = 2'd1;
  localparam int         FUNC_RESTART_BIT = 1;

  localparam logic [1:0] STAT_SERVED    = 2'd0;
  localparam logic [1:0] STAT_EXPEDITED = 2'd1;
  localparam logic [1:0] STAT_DROPPED   = 2'd2;
  localparam logic [1:0] STAT_RESTARTED = 2'd3;

  localparam logic        REG_IDX_POPULATION = 1'b0;
  localparam logic [31:0] POPULATION_RESET   = 32'd1;

endpackage

>>> hdl/rrmtf_mem.sv
module rrmtf_mem
  import rrmtf_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  mem_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rrmtf_agu.sv
module rrmtf_agu
  import rrmtf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 32
) (
  input  logic [$clog2(QUEUE_DEPTH)-1:0]   head,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] idx,
  input  logic [ID_WIDTH-1:0]              lhs,
  input  logic [ID_WIDTH-1:0]              rhs,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   slot,
  output logic                             eq
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  assign sum     = SW'(head) + SW'(idx);
  assign wrapped = sum - SW'(QUEUE_DEPTH);
  assign slot    = (sum >= SW'(QUEUE_DEPTH)) ? AW'(wrapped) : AW'(sum);
  assign eq      = (lhs == rhs);

endmodule

>>> hdl/round_robin_move_to_front_queue.sv
// Channel   Handshake                      Payload
// input     start / busy                   in_func, in_requester_id
// result    out_strobe (one cycle, no stall) out_served_id, out_status
// config    APB psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One item at a time; busy is high from the cycle after acceptance until the result beat
// (a serve on an empty queue answers from idle). Serve moves the head entry to the tail;
// restart loads IDs 1 to n. Expedite makes one pass of the single compare unit to find
// the ID, then one store write per entry moved (or puts a missing ID ahead of the head).
// Reset clears the head and entry count; the ID store itself is never cleared.
// The result beat cannot be held off, so nothing ever waits on the receiver.
module round_robin_move_to_front_queue
  import rrmtf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_requester_id,
  output logic        out_strobe,
  output logic [31:0] out_served_id,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     rd_slot_r, rd_slot_nxt;
  logic [31:0]       pop_r;
  logic              out_strobe_r, out_strobe_nxt;
  logic [31:0]       out_served_r, out_served_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  mem_ctl_t            mem_ctl;
  logic [AW-1:0]       mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [ID_WIDTH-1:0] mem_rdata;

  logic [CW-1:0]       agu_idx;
  logic [AW-1:0]       agu_slot;
  logic                agu_eq;

  logic                accept;
  logic                cfg_wr;
  logic                hit;
  logic [CW-1:0]       n_cap;
  logic [SW-1:0]       kp1;
  logic [63:0]         req_wide;
  logic [63:0]         rd_wide;
  logic [ID_WIDTH-1:0] id_in;
  logic [AW-1:0]       head_inc;
  logic [AW-1:0]       head_dec;
  logic [AW-1:0]       wr_slot;

  rrmtf_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ID_WIDTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrmtf_agu #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_agu (
    .head (head_r),
    .idx  (agu_idx),
    .lhs  (mem_rdata),
    .rhs  (id_r),
    .slot (agu_slot),
    .eq   (agu_eq)
  );

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_POPULATION);
  assign prdata     = (paddr[2] == REG_IDX_POPULATION) ? pop_r : 32'd0;

  assign req_wide   = 64'(in_requester_id);
  assign id_in      = req_wide[ID_WIDTH-1:0];
  assign rd_wide    = 64'(mem_rdata);
  assign n_cap      = (pop_r >= 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(pop_r);
  assign kp1        = SW'(k_r) + 1'b1;
  assign hit        = cmp_vld_r && agu_eq;
  assign head_inc   = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec   = (head_r == '0) ? AW'(QUEUE_DEPTH - 1) : head_r - 1'b1;
  assign wr_slot    = (rd_slot_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func[FUNC_RESTART_BIT]) begin
            state_nxt = S_LOAD;
          end else if (in_func == FUNC_SERVE) begin
            state_nxt = (count_r != '0) ? S_SRV_RD : S_IDLE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_LOAD: begin
        if (k_r == n_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_SRV_RD: state_nxt = S_SRV_WR;
      S_SRV_WR: state_nxt = S_IDLE;
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_SHIFT;
        end else if (k_r == count_r) begin
          state_nxt = S_INSERT;
        end
      end
      S_SHIFT: begin
        if (k_r == '0) begin
          state_nxt = S_FRONT;
        end
      end
      S_FRONT:  state_nxt = S_IDLE;
      S_INSERT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    id_nxt         = id_r;
    cmp_vld_nxt    = 1'b0;
    pend_nxt       = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    out_strobe_nxt = 1'b0;
    out_served_nxt = out_served_r;
    out_status_nxt = out_status_r;
    mem_ctl        = '0;
    agu_idx        = k_r;
    mem_waddr      = agu_slot;
    mem_raddr      = agu_slot;
    mem_wdata      = id_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func[FUNC_RESTART_BIT]) begin
            n_nxt     = n_cap;
            k_nxt     = '0;
            head_nxt  = '0;
            count_nxt = n_cap;
          end else if (in_func == FUNC_SERVE) begin
            if (count_r == '0) begin
              out_strobe_nxt = 1'b1;
              out_served_nxt = 32'd0;
              out_status_nxt = STAT_SERVED;
            end
          end else begin
            id_nxt = id_in;
            k_nxt  = '0;
          end
        end
      end
      S_LOAD: begin
        if (k_r == n_r) begin
          out_strobe_nxt = 1'b1;
          out_served_nxt = 32'd0;
          out_status_nxt = STAT_RESTARTED;
        end else begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = k_r[AW-1:0];
          mem_wdata     = ID_WIDTH'(kp1);
          k_nxt         = k_r + 1'b1;
        end
      end
      S_SRV_RD: begin
        agu_idx       = '0;
        mem_ctl.rd_en = 1'b1;
      end
      S_SRV_WR: begin
        agu_idx        = count_r;
        mem_ctl.wr_en  = 1'b1;
        mem_wdata      = mem_rdata;
        head_nxt       = head_inc;
        out_strobe_nxt = 1'b1;
        out_served_nxt = rd_wide[31:0];
        out_status_nxt = STAT_SERVED;
      end
      S_SCAN: begin
        if (hit) begin
          k_nxt = k_r - 1'b1;
        end else if (k_r != count_r) begin
          mem_ctl.rd_en = 1'b1;
          cmp_vld_nxt   = 1'b1;
          k_nxt         = k_r + 1'b1;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          mem_ctl.wr_en = 1'b1;
          mem_waddr     = wr_slot;
          mem_wdata     = mem_rdata;
        end
        if (k_r != '0) begin
          agu_idx       = k_r - 1'b1;
          mem_ctl.rd_en = 1'b1;
          rd_slot_nxt   = agu_slot;
          pend_nxt      = 1'b1;
          k_nxt         = k_r - 1'b1;
        end
      end
      S_FRONT: begin
        mem_ctl.wr_en  = 1'b1;
        mem_waddr      = head_r;
        out_strobe_nxt = 1'b1;
        out_served_nxt = 32'd0;
        out_status_nxt = STAT_EXPEDITED;
      end
      S_INSERT: begin
        mem_ctl.wr_en  = 1'b1;
        mem_waddr      = head_dec;
        head_nxt       = head_dec;
        out_strobe_nxt = 1'b1;
        out_served_nxt = 32'd0;
        if (count_r < CW'(QUEUE_DEPTH)) begin
          count_nxt      = count_r + 1'b1;
          out_status_nxt = STAT_EXPEDITED;
        end else begin
          out_status_nxt = STAT_DROPPED;
        end
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      cmp_vld_r    <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      pop_r        <= POPULATION_RESET;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr) begin
        pop_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    id_r         <= id_nxt;
    rd_slot_r    <= rd_slot_nxt;
    out_served_r <= out_served_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_served_id = out_served_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en && mem_ctl.rd_en |-> mem_waddr != mem_raddr)
    else $error("store read and write hit the same slot");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_SHIFT)
    else $error("pending shift write outside the shift phase");

  a_empty_serve: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_func[FUNC_RESTART_BIT] && in_func == FUNC_SERVE && count_r == '0
      |=> out_strobe && !busy)
    else $error("serve on an empty queue did not finish at once");

  a_strobe_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == S_IDLE || $past(state_r) == S_LOAD ||
                   $past(state_r) == S_SRV_WR || $past(state_r) == S_FRONT ||
                   $past(state_r) == S_INSERT)
    else $error("result beat from a working phase");
`endif

endmodule
